// ===== hdl/lpsbe_pkg.sv =====
`timescale 1ns / 1ps

package lpsbe_pkg;

    localparam int MaxLedsDefault  = 1024;
    localparam int BytesPerPixel   = 9;
    localparam int PreambleBytes   = 1;
    localparam int BytesPerChannel = 3;

    localparam int IdxW = 10;
    localparam int ColW = 24;
    localparam int ChW  = 8;
    localparam int OffW = 14;
    localparam int EncW = 24;

    // Opcode values of an input transfer.
    localparam logic OpRaw    = 1'b0;
    localparam logic OpScaled = 1'b1;

    typedef struct packed {
        logic            opcode;
        logic [IdxW-1:0] pixel_index;
        logic [ColW-1:0] color;
    } t_pix_in;

    typedef struct packed {
        logic [OffW-1:0] byte_offset;
        logic [EncW-1:0] encoded_bits;
        logic            last_of_pixel;
    } t_pix_out;

    // Each data bit becomes three line bits, MSB first: a one as 110, a zero as 100.
    function automatic logic [EncW-1:0] encode_channel(input logic [ChW-1:0] v);
        logic [EncW-1:0] pat;
        pat = '0;
        for (int i = 0; i < ChW; i++) begin
            pat[3*i+2] = 1'b1;
            pat[3*i+1] = v[i];
            pat[3*i]   = 1'b0;
        end
        return pat;
    endfunction

endpackage

// ===== hdl/led_pixel_spi_bit_encoder.sv =====
`timescale 1ns / 1ps

// The three results of a pixel leave the serialiser one per cycle (green, red, blue), each
// for one cycle, after the pixel has passed the capture, scaling and encoding registers.
// The single result port takes one pixel at a time; the three register stages ahead of
// the output serialiser hold further pixels while it is busy.
// Reset (synchronous, active low) empties the pipeline and clears the brightness to zero.
// The receiver cannot stall; busy only reflects back-pressure from the serialiser.
module led_pixel_spi_bit_encoder #(
    parameter int MAX_LEDS = lpsbe_pkg::MaxLedsDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lpsbe_pkg::t_pix_in         i_pix,
    input  logic                       i_cfg_we,
    input  logic [lpsbe_pkg::ChW-1:0]  i_cfg_wdata,
    output logic                       o_strobe,
    output lpsbe_pkg::t_pix_out        o_result
);

    localparam int ChW  = lpsbe_pkg::ChW;
    localparam int OffW = lpsbe_pkg::OffW;
    localparam int EncW = lpsbe_pkg::EncW;

    logic [ChW-1:0] r_scale;

    // Stage 1: captured input.
    logic               r_v1;
    lpsbe_pkg::t_pix_in r_s1;

    // Stage 2: scaled channels (green, red, blue) and base address.
    logic            r_v2;
    logic [ChW-1:0]  r_ch2 [3];
    logic [OffW-1:0] r_base2;

    // Stage 3: encoded channels.
    logic            r_v3;
    logic [EncW-1:0] r_enc3 [3];
    logic [OffW-1:0] r_base3;

    // Serialiser.
    logic            r_sv;
    logic [1:0]      r_beat;
    logic [EncW-1:0] r_senc [3];
    logic [OffW-1:0] r_off;

    logic adv1, adv2, adv3, accept, in_range, scale_on;
    logic [2*ChW-1:0] prod [3];
    logic [ChW-1:0]   n_ch [3];
    logic [OffW-1:0]  n_base;

    assign adv3   = ~r_sv | (r_beat == 2'd2);
    assign adv2   = ~r_v3 | adv3;
    assign adv1   = ~r_v2 | adv2;
    assign busy   = r_v1 & ~adv1;
    assign accept = start & ~busy;

    assign in_range = 32'(i_pix.pixel_index) < MAX_LEDS;
    assign scale_on = (r_s1.opcode == lpsbe_pkg::OpScaled) && (r_scale != '0);

    always_comb begin
        prod[0] = 16'(r_s1.color[15:8])  * 16'(r_scale);
        prod[1] = 16'(r_s1.color[23:16]) * 16'(r_scale);
        prod[2] = 16'(r_s1.color[7:0])   * 16'(r_scale);
        n_ch[0] = scale_on ? prod[0][15:8] : r_s1.color[15:8];
        n_ch[1] = scale_on ? prod[1][15:8] : r_s1.color[23:16];
        n_ch[2] = scale_on ? prod[2][15:8] : r_s1.color[7:0];
        // index * 9 as index * 8 + index, then the preamble byte.
        n_base  = (OffW'(r_s1.pixel_index) << 3) + OffW'(r_s1.pixel_index)
                  + OffW'(lpsbe_pkg::PreambleBytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_sv    <= 1'b0;
            r_beat  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end

            // Each stage loads whenever it is empty or its content moves on.
            if (!busy) begin
                r_v1 <= accept & in_range;
                r_s1 <= i_pix;
            end

            if (adv1) begin
                r_v2    <= r_v1;
                r_ch2   <= n_ch;
                r_base2 <= n_base;
            end

            if (adv2) begin
                r_v3 <= r_v2;
                for (int k = 0; k < 3; k++) begin
                    r_enc3[k] <= lpsbe_pkg::encode_channel(r_ch2[k]);
                end
                r_base3 <= r_base2;
            end

            if (r_v3 && adv3) begin
                r_sv   <= 1'b1;
                r_beat <= '0;
                r_senc <= r_enc3;
                r_off  <= r_base3;
            end else if (r_sv) begin
                if (r_beat == 2'd2) begin
                    r_sv <= 1'b0;
                end else begin
                    r_beat <= r_beat + 2'd1;
                    r_off  <= r_off + OffW'(lpsbe_pkg::BytesPerChannel);
                end
            end
        end
    end

    always_comb begin
        o_strobe               = r_sv;
        o_result.byte_offset   = r_off;
        o_result.last_of_pixel = (r_beat == 2'd2);
        unique case (r_beat)
            2'd0:    o_result.encoded_bits = r_senc[0];
            2'd1:    o_result.encoded_bits = r_senc[1];
            default: o_result.encoded_bits = r_senc[2];
        endcase
    end

    // A pixel's three results follow one another without a gap.
    a_beats_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_of_pixel) |=> o_strobe)
        else $error("result transfers of a pixel not contiguous");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_of_pixel) |=>
        (o_result.byte_offset == $past(o_result.byte_offset) + OffW'(3)))
        else $error("byte offset did not advance by one channel");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && in_range) |=> r_v1)
        else $error("accepted pixel lost at the first stage");

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_v1 && r_v2 && r_v3 && r_sv))
        else $error("busy raised with room in the pipeline");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    lpsbe_pkg::t_pix_in            i_pix       = '0;
    logic                          i_cfg_we    = 1'b0;
    logic [lpsbe_pkg::ChW-1:0]     i_cfg_wdata = '0;
    logic                          o_strobe;
    lpsbe_pkg::t_pix_out           o_result;

    // Testbench copy of the brightness register.
    logic [lpsbe_pkg::ChW-1:0] brightness = '0;
    // Channel results still to come, oldest first.
    lpsbe_pkg::t_pix_out pending_channels[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_pct = 0;

    led_pixel_spi_bit_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pix       (i_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Line pattern of one channel: each data bit, MSB first, as 1 d 0.
    function automatic logic [lpsbe_pkg::EncW-1:0] spi_pattern(
        input logic [lpsbe_pkg::ChW-1:0] level);
        logic [lpsbe_pkg::EncW-1:0] pat;
        pat = '0;
        for (int b = lpsbe_pkg::ChW - 1; b >= 0; b--)
            pat = {pat[lpsbe_pkg::EncW-4:0], 1'b1, level[b], 1'b0};
        return pat;
    endfunction

    function automatic logic [lpsbe_pkg::ChW-1:0] dim_channel(
        input logic [lpsbe_pkg::ChW-1:0] level, input logic scaled);
        logic [15:0] product;
        product = 16'(level) * 16'(brightness);
        if (scaled == lpsbe_pkg::OpScaled && brightness != '0)
            return product[15:8];
        return level;
    endfunction

    // Queues the green, red and blue results of one accepted pixel.
    function automatic void predict_pixel(input lpsbe_pkg::t_pix_in px);
        logic [lpsbe_pkg::ChW-1:0] levels[3];
        lpsbe_pkg::t_pix_out res;
        int base;
        if (int'(px.pixel_index) >= lpsbe_pkg::MaxLedsDefault)
            return;
        levels[0] = dim_channel(px.color[15:8], px.opcode);
        levels[1] = dim_channel(px.color[23:16], px.opcode);
        levels[2] = dim_channel(px.color[7:0], px.opcode);
        base = int'(px.pixel_index) * lpsbe_pkg::BytesPerPixel + lpsbe_pkg::PreambleBytes;
        for (int k = 0; k < 3; k++) begin
            res.byte_offset   = lpsbe_pkg::OffW'(base + lpsbe_pkg::BytesPerChannel * k);
            res.encoded_bits  = spi_pattern(levels[k]);
            res.last_of_pixel = (k == 2);
            pending_channels.push_back(res);
        end
    endfunction

    task automatic send_pixel(input logic op, input logic [lpsbe_pkg::IdxW-1:0] idx,
                              input logic [lpsbe_pkg::ColW-1:0] color);
        lpsbe_pkg::t_pix_in px;
        px.opcode      = op;
        px.pixel_index = idx;
        px.color       = color;
        i_pix <= px;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_pixel(px);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Lets every outstanding result arrive, then waits on so that the block is idle.
    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_channels.size() != 0 && waited < 400) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_brightness(input logic [lpsbe_pkg::ChW-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        brightness = value;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        lpsbe_pkg::t_pix_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_channels.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, o_result);
                mismatch_count++;
            end else begin
                want = pending_channels.pop_front();
                if (o_result.byte_offset !== want.byte_offset) begin
                    $display("%0t: byte_offset expected %0d, got %0d", $time,
                             want.byte_offset, o_result.byte_offset);
                    mismatch_count++;
                end
                if (o_result.encoded_bits !== want.encoded_bits) begin
                    $display("%0t: encoded_bits expected %h, got %h", $time,
                             want.encoded_bits, o_result.encoded_bits);
                    mismatch_count++;
                end
                if (o_result.last_of_pixel !== want.last_of_pixel) begin
                    $display("%0t: last_of_pixel expected %b, got %b", $time,
                             want.last_of_pixel, o_result.last_of_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    // Brightness is still zero here, so scaled pixels must pass unchanged.
    task automatic test_raw_and_zero_scale();
        idle_pct = 0;
        send_pixel(lpsbe_pkg::OpRaw,    10'd0,    24'h000000);
        send_pixel(lpsbe_pkg::OpRaw,    10'd1023, 24'hFFFFFF);
        send_pixel(lpsbe_pkg::OpRaw,    10'd512,  24'hA5C30F);
        send_pixel(lpsbe_pkg::OpScaled, 10'd1,    24'h123456);
        send_pixel(lpsbe_pkg::OpScaled, 10'd1023, 24'hFFFFFF);
        send_pixel(lpsbe_pkg::OpRaw,    10'd341,  24'h800001);
        drain_results();
    endtask

    task automatic test_scale_extremes();
        idle_pct = 0;
        write_brightness(8'd255);
        send_pixel(lpsbe_pkg::OpScaled, 10'd0,    24'hFFFFFF);
        send_pixel(lpsbe_pkg::OpScaled, 10'd1023, 24'h010203);
        send_pixel(lpsbe_pkg::OpRaw,    10'd7,    24'hFFFFFF);
        send_pixel(lpsbe_pkg::OpScaled, 10'd100,  24'h80FF7F);
        drain_results();
        write_brightness(8'd1);
        send_pixel(lpsbe_pkg::OpScaled, 10'd5,    24'hFFFFFF);
        send_pixel(lpsbe_pkg::OpScaled, 10'd6,    24'h000000);
        send_pixel(lpsbe_pkg::OpRaw,    10'd8,    24'h5A5A5A);
        drain_results();
        write_brightness(8'd128);
        send_pixel(lpsbe_pkg::OpScaled, 10'd9,    24'hFF8001);
        send_pixel(lpsbe_pkg::OpScaled, 10'd1022, 24'hC0FFEE);
        drain_results();
    endtask

    // Random pixels, with a fresh brightness every 40 transfers.
    task automatic test_random_traffic(input int unsigned pct, input int count);
        logic [lpsbe_pkg::ChW-1:0] level;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                drain_results();
                case ($urandom_range(4))
                    0:       level = 8'd0;
                    1:       level = 8'd255;
                    default: level = lpsbe_pkg::ChW'($urandom_range(255));
                endcase
                write_brightness(level);
            end
            send_pixel(logic'($urandom_range(1)), lpsbe_pkg::IdxW'($urandom_range(1023)),
                       lpsbe_pkg::ColW'($urandom));
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_raw_and_zero_scale();
        test_scale_extremes();
        test_random_traffic(0, 120);
        test_random_traffic(69, 120);
        test_random_traffic(19, 120);
        test_random_traffic(0, 120);
        mismatch_count += pending_channels.size();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lpsbe_pkg.sv
hdl/led_pixel_spi_bit_encoder.sv
tb/tb.sv
